/* src/tangent_space_normal_perturb_assert.svh */
// Assertion macros for the normal perturb block and its checker.
`ifndef TANGENT_SPACE_NORMAL_PERTURB_ASSERT_SVH
`define TANGENT_SPACE_NORMAL_PERTURB_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define TSN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsn check failed");

// Next-cycle implication, clocked on clk, off while in reset.
`define TSN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsn check failed");

`endif

/* src/tsn_pkg.sv */
package tsn_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W      = 16;
	localparam int D_W       = 17;                 // decoded texel, 2c-65535
	localparam int P_W       = 34;                 // t*d + n*d
	localparam int X_W       = 32;                 // t*n products
	localparam int B_W       = 33;                 // cross product terms
	localparam int S_W       = 50;                 // unnormalized vector
	localparam int MAG_W     = 49;
	localparam int NRM_W     = 30;                 // normalized magnitude
	localparam int NRM_TOP   = NRM_W - 1;
	localparam int SH_W      = 6;
	localparam int SQ_W      = 2 * NRM_W + 2;      // sum of three squares
	localparam int ROOT_W    = SQ_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int NUM_W     = NRM_W + FRAC_BITS + 2;
	localparam int DEN_W     = ROOT_W + 1;
	localparam int Q_W       = NUM_W - DEN_W + 3;
	localparam int CMP_W     = DEN_W + Q_W;
	localparam int POS_MAX   = 32767;
	localparam int NEG_MAX   = 32768;
	localparam logic signed [D_W:0] TEX_BIAS = 18'sd65535;

	typedef struct packed {
		logic signed [IN_W-1:0] geo_normal_x;
		logic signed [IN_W-1:0] geo_normal_y;
		logic signed [IN_W-1:0] geo_normal_z;
		logic signed [IN_W-1:0] tangent_x;
		logic signed [IN_W-1:0] tangent_y;
		logic signed [IN_W-1:0] tangent_z;
		logic [IN_W-1:0]        texel_red;
		logic [IN_W-1:0]        texel_green;
		logic [IN_W-1:0]        texel_blue;
	} sample_t;

	typedef struct packed {
		logic signed [IN_W-1:0] shade_normal_x;
		logic signed [IN_W-1:0] shade_normal_y;
		logic signed [IN_W-1:0] shade_normal_z;
		logic                   degenerate;
	} shade_t;

endpackage

/* src/tsn_sample_if.sv */
interface tsn_sample_if;
	import tsn_pkg::*;
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/tsn_shade_if.sv */
interface tsn_shade_if;
	import tsn_pkg::*;
	logic   valid;
	logic   ready;
	shade_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/tangent_space_normal_perturb.sv */
// Throughput: one transaction per cycle; the whole pipe holds while the
// output register is full and not taken, so nothing is lost or repeated.
// Depth is set by the 31-step square root and the 17-step rounding divide.
// Reset (arst_n low, async): all valid bits and the enable register en_q clear.
module tangent_space_normal_perturb (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	tsn_sample_if.sink    sample,
	tsn_shade_if.source   shade
);
	import tsn_pkg::*;

	localparam int SQ_N = ROOT_W;   // sqrt steps, one bit of root each
	localparam int DV_N = Q_W;      // divide steps, one quotient bit each

	// Payload carried down the pipe once the vector is normalized.
	typedef struct packed {
		logic                        en;
		logic                        zero;
		logic [2:0]                  neg;
		logic [2:0][NRM_W-1:0]       mag;
		logic [2:0][IN_W-1:0]        geo;
	} carry_t;

	logic en_q;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_we) begin
			en_q <= cfg_wdata;
		end
	end

	// Single global stall: the pipe moves whenever the output slot frees.
	assign adv          = !shade.valid || shade.ready;
	assign sample.ready = adv;

	// ---------------- decode of the incoming transaction ----------------
	logic signed [IN_W-1:0] tv [3];
	logic signed [IN_W-1:0] nv [3];
	logic signed [D_W-1:0]  dv [3];
	logic [IN_W-1:0]        cv [3];
	logic signed [D_W:0]    dwide [3];

	always_comb begin
		nv[0] = sample.data.geo_normal_x;
		nv[1] = sample.data.geo_normal_y;
		nv[2] = sample.data.geo_normal_z;
		tv[0] = sample.data.tangent_x;
		tv[1] = sample.data.tangent_y;
		tv[2] = sample.data.tangent_z;
		cv[0] = sample.data.texel_red;
		cv[1] = sample.data.texel_green;
		cv[2] = sample.data.texel_blue;
		for (int i = 0; i < 3; i++) begin
			// 2c - 65535: always odd, never zero
			dwide[i] = $signed({1'b0, cv[i], 1'b0}) - TEX_BIAS;
			dv[i]    = dwide[i][D_W-1:0];
		end
	end

	// ---------------- s1: all first-level products ----------------
	logic                  vld_s1, en_s1;
	logic signed [B_W-1:0] pt_s1 [3];
	logic signed [B_W-1:0] pn_s1 [3];
	logic signed [X_W-1:0] x_s1  [6];
	logic signed [D_W-1:0] d1_s1;
	logic [2:0][IN_W-1:0]  geo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pt_s1[i]  <= tv[i] * dv[0];
				pn_s1[i]  <= nv[i] * dv[2];
				geo_s1[i] <= nv[i];
			end
			// cross product terms of B = T x N
			x_s1[0] <= tv[1] * nv[2];
			x_s1[1] <= tv[2] * nv[1];
			x_s1[2] <= tv[2] * nv[0];
			x_s1[3] <= tv[0] * nv[2];
			x_s1[4] <= tv[0] * nv[1];
			x_s1[5] <= tv[1] * nv[0];
			d1_s1   <= dv[1];
			en_s1   <= en_q;
		end
	end

	// ---------------- s2: sums and bitangent ----------------
	logic                  vld_s2, en_s2;
	logic signed [P_W-1:0] a_s2 [3];
	logic signed [B_W-1:0] b_s2 [3];
	logic signed [D_W-1:0] d1_s2;
	logic [2:0][IN_W-1:0]  geo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= P_W'(pt_s1[i]) + P_W'(pn_s1[i]);
				b_s2[i] <= B_W'(x_s1[2*i]) - B_W'(x_s1[2*i+1]);
			end
			d1_s2  <= d1_s1;
			geo_s2 <= geo_s1;
			en_s2  <= en_s1;
		end
	end

	// ---------------- s3: S = (T*Dx + N*Dz) << F + B*Dy ----------------
	logic                  vld_s3, en_s3;
	logic signed [S_W-1:0] s_s3 [3];
	logic [2:0][IN_W-1:0]  geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				s_s3[i] <= (S_W'(a_s2[i]) <<< FRAC_BITS) + S_W'(b_s2[i] * d1_s2);
			end
			geo_s3 <= geo_s2;
			en_s3  <= en_s2;
		end
	end

	// ---------------- s4: sign / magnitude ----------------
	logic                 vld_s4, en_s4;
	logic [2:0]           neg_s4;
	logic [MAG_W-1:0]     mag_s4 [3];
	logic [MAG_W-1:0]     any_s4;
	logic [2:0][IN_W-1:0] geo_s4;
	logic [S_W-1:0]       abs_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = s_s3[i][S_W-1] ? S_W'(-s_s3[i]) : S_W'(s_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= s_s3[i][S_W-1];
				mag_s4[i] <= abs_c[i][MAG_W-1:0];
			end
			// leading one of the OR equals that of the largest magnitude
			any_s4 <= abs_c[0][MAG_W-1:0] | abs_c[1][MAG_W-1:0] | abs_c[2][MAG_W-1:0];
			geo_s4 <= geo_s3;
			en_s4  <= en_s3;
		end
	end

	// ---------------- s5: normalizing shift amount ----------------
	logic                 vld_s5, en_s5, zero_s5, right_s5;
	logic [SH_W-1:0]      amt_s5;
	logic [2:0]           neg_s5;
	logic [MAG_W-1:0]     mag_s5 [3];
	logic [2:0][IN_W-1:0] geo_s5;
	logic [SH_W-1:0]      msb_c;

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (any_s4[i]) msb_c = SH_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s5  <= (any_s4 == '0);
			right_s5 <= (msb_c > SH_W'(NRM_TOP));
			amt_s5   <= (msb_c > SH_W'(NRM_TOP)) ? msb_c - SH_W'(NRM_TOP)
			                                      : SH_W'(NRM_TOP) - msb_c;
			neg_s5   <= neg_s4;
			mag_s5   <= mag_s4;
			geo_s5   <= geo_s4;
			en_s5    <= en_s4;
		end
	end

	// ---------------- s6: apply shift (down truncates, up exact) ----------------
	logic   vld_s6;
	carry_t c_s6;
	logic [MAG_W-1:0] shr_c [3];
	logic [MAG_W-1:0] shl_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shr_c[i] = mag_s5[i] >> amt_s5;
			shl_c[i] = mag_s5[i] << amt_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (adv) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c_s6.mag[i] <= right_s5 ? shr_c[i][NRM_W-1:0] : shl_c[i][NRM_W-1:0];
			end
			c_s6.neg  <= neg_s5;
			c_s6.zero <= zero_s5;
			c_s6.en   <= en_s5;
			c_s6.geo  <= geo_s5;
		end
	end

	// ---------------- s7: squares ----------------
	logic                 vld_s7;
	carry_t               c_s7;
	logic [2*NRM_W-1:0]   sqr_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (adv) vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s7[i] <= c_s6.mag[i] * c_s6.mag[i];
			end
			c_s7 <= c_s6;
		end
	end

	// ---------------- square root: one root bit per stage ----------------
	logic              sq_vld_s [SQ_N+1];
	carry_t            sq_c_s   [SQ_N+1];
	logic [SQ_W-1:0]   sq_rad_s [SQ_N+1];
	logic [REM_W-1:0]  sq_rem_s [SQ_N+1];
	logic [ROOT_W-1:0] sq_root_s[SQ_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld_s[0] <= 1'b0;
		else if (adv) sq_vld_s[0] <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rad_s[0]  <= SQ_W'(sqr_s7[0]) + SQ_W'(sqr_s7[1]) + SQ_W'(sqr_s7[2]);
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_c_s[0]    <= c_s7;
		end
	end

	for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
		localparam int PB = 2 * (SQ_N - k);
		logic [REM_W+1:0] rx;
		logic [REM_W+1:0] trial;
		logic             take;

		always_comb begin
			rx    = {sq_rem_s[k-1], sq_rad_s[k-1][PB+1:PB]};
			trial = (REM_W+2)'({sq_root_s[k-1], 2'b01});
			take  = (rx >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k] <= 1'b0;
			else if (adv) sq_vld_s[k] <= sq_vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[k]  <= take ? REM_W'(rx - trial) : REM_W'(rx);
				sq_root_s[k] <= {sq_root_s[k-1][ROOT_W-2:0], take};
				sq_rad_s[k]  <= sq_rad_s[k-1];
				sq_c_s[k]    <= sq_c_s[k-1];
			end
		end
	end

	// ---------------- rounding divide: (2*num + len) / (2*len) ----------------
	logic             dv_vld_s [DV_N+1];
	carry_t           dv_c_s   [DV_N+1];
	logic [NUM_W-1:0] dv_rem_s [3][DV_N+1];
	logic [DEN_W-1:0] dv_den_s [DV_N+1];
	logic [Q_W-1:0]   dv_q_s   [3][DV_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld_s[0] <= 1'b0;
		else if (adv) dv_vld_s[0] <= sq_vld_s[SQ_N];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[i][0] <= {sq_c_s[SQ_N].mag[i], {FRAC_BITS{1'b0}}, 1'b0}
				                  + NUM_W'(sq_root_s[SQ_N]);
				dv_q_s[i][0]   <= '0;
			end
			dv_den_s[0] <= {sq_root_s[SQ_N], 1'b0};
			dv_c_s[0]   <= sq_c_s[SQ_N];
		end
	end

	for (genvar k = 1; k <= DV_N; k++) begin : g_div
		localparam int QB = DV_N - k;
		logic [CMP_W-1:0] dsh;
		logic [CMP_W-1:0] rw [3];
		logic [2:0]       ge;

		always_comb begin
			dsh = CMP_W'(dv_den_s[k-1]) << QB;
			for (int i = 0; i < 3; i++) begin
				rw[i] = CMP_W'(dv_rem_s[i][k-1]);
				ge[i] = (rw[i] >= dsh);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[k] <= 1'b0;
			else if (adv) dv_vld_s[k] <= dv_vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[i][k] <= ge[i] ? NUM_W'(rw[i] - dsh) : dv_rem_s[i][k-1];
					dv_q_s[i][k]   <= {dv_q_s[i][k-1][Q_W-2:0], ge[i]};
				end
				dv_den_s[k] <= dv_den_s[k-1];
				dv_c_s[k]   <= dv_c_s[k-1];
			end
		end
	end

	// ---------------- output register: clamp, sign, passthrough ----------------
	logic                 out_vld_q;
	shade_t               out_q;
	logic [IN_W-1:0]      res_c [3];
	logic [Q_W-1:0]       qf    [3];
	carry_t               cf;

	always_comb begin
		cf = dv_c_s[DV_N];
		for (int i = 0; i < 3; i++) begin
			qf[i] = dv_q_s[i][DV_N];
			if (!cf.en || cf.zero) begin
				res_c[i] = cf.geo[i];
			end else if (cf.neg[i]) begin
				res_c[i] = (qf[i] > Q_W'(NEG_MAX)) ? IN_W'(NEG_MAX) : IN_W'(-qf[i]);
			end else begin
				res_c[i] = (qf[i] > Q_W'(POS_MAX)) ? IN_W'(POS_MAX) : qf[i][IN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= dv_vld_s[DV_N];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.shade_normal_x <= res_c[0];
			out_q.shade_normal_y <= res_c[1];
			out_q.shade_normal_z <= res_c[2];
			out_q.degenerate     <= cf.en && cf.zero;
		end
	end

	assign shade.valid = out_vld_q;
	assign shade.data  = out_q;

endmodule

/* src/tsn_checker.sv */
module tsn_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input tsn_pkg::shade_t out_data
);
	import tsn_pkg::*;
`include "tangent_space_normal_perturb_assert.svh"

	// protocol: result holds until taken
	`TSN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`TSN_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
	// a stalled output blocks new transactions (global pipe stall)
	`TSN_ASSERT_IMP(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
	// output slot free means input is open
	`TSN_ASSERT_IMP(a_free_accepts, !out_valid, in_ready)
	// nothing comes out right after reset ends
	`TSN_ASSERT_IMP(a_reset_empty, $rose(arst_n), !out_valid && !in_valid || !out_valid)

endmodule

bind tangent_space_normal_perturb tsn_checker u_tsn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (shade.valid),
	.out_ready (shade.ready),
	.out_data  (shade.data)
);
